// ----- hw/rtl/grid_block_pixel_fill_unit_assert.svh -----
// assertion macros used by the grid block pixel fill checker
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef GRID_BLOCK_PIXEL_FILL_UNIT_ASSERT_SVH
`define GRID_BLOCK_PIXEL_FILL_UNIT_ASSERT_SVH

// same-cycle implication
`define GBPF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GBPF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/gbpf_pkg.sv -----
// types, constants, microcode table and color packing for the grid block pixel fill unit
// no dependencies
package gbpf_pkg;

    localparam int unsigned GRID_COLUMNS = 512;
    localparam int unsigned GRID_ROWS    = 256;
    localparam int unsigned COL_SHIFT    = $clog2(GRID_COLUMNS);
    localparam int unsigned ROW_SHIFT    = $clog2(GRID_ROWS);

    localparam int unsigned MAX_WRITES = 64;
    localparam int unsigned CNT_W      = $clog2(MAX_WRITES);

    localparam int unsigned ADDR_W  = 64;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned W_W     = 13;
    localparam int unsigned H_W     = 12;
    localparam int unsigned PITCH_W = 15;
    localparam int unsigned PB_W    = 3;
    localparam int unsigned FMT_W   = 9;
    localparam int unsigned PROD_W  = W_W + PITCH_W;
    localparam int unsigned CFG_IDX_W = 4;

    localparam logic [9:0] BLOCK_COL_LIMIT = 10'd511;
    localparam logic [8:0] BLOCK_ROW_LIMIT = 9'd255;
    localparam logic [PB_W-1:0] PB_MAX     = 3'd4;

    localparam logic [ADDR_W-1:0]  RST_FRAME_BASE    = 64'd0;
    localparam logic [W_W-1:0]     RST_SCREEN_WIDTH  = 13'd640;
    localparam logic [H_W-1:0]     RST_SCREEN_HEIGHT = 12'd480;
    localparam logic [PITCH_W-1:0] RST_ROW_PITCH     = 15'd2560;
    localparam logic [PB_W-1:0]    RST_PIXEL_BYTES   = 3'd4;
    localparam logic [FMT_W-1:0]   RST_RED_FORMAT    = 9'd264;
    localparam logic [FMT_W-1:0]   RST_GREEN_FORMAT  = 9'd136;
    localparam logic [FMT_W-1:0]   RST_BLUE_FORMAT   = 9'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_BASE    = 4'd0,
        CFG_SCREEN_WIDTH  = 4'd1,
        CFG_SCREEN_HEIGHT = 4'd2,
        CFG_ROW_PITCH     = 4'd3,
        CFG_PIXEL_BYTES   = 4'd4,
        CFG_RED_FORMAT    = 4'd5,
        CFG_GREEN_FORMAT  = 4'd6,
        CFG_BLUE_FORMAT   = 4'd7
    } t_cfg_reg;

    typedef struct packed {
        logic [9:0] block_col;
        logic [8:0] block_row;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_cmd;

    typedef struct packed {
        logic [ADDR_W-1:0] write_address;
        logic [DATA_W-1:0] write_data;
        logic [PB_W-1:0]   write_bytes;
        logic              last;
    } t_result;

    typedef enum logic [3:0] {
        STEP_IDLE    = 4'd0,
        STEP_MUL_X0  = 4'd1,
        STEP_MUL_X1  = 4'd2,
        STEP_MUL_Y0  = 4'd3,
        STEP_MUL_Y1  = 4'd4,
        STEP_MUL_ROW = 4'd5,
        STEP_MUL_COL = 4'd6,
        STEP_START   = 4'd7,
        STEP_EMIT    = 4'd8
    } t_step;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_X0,
        MUL_X1,
        MUL_Y0,
        MUL_Y1,
        MUL_ROW,
        MUL_COL
    } t_mul_sel;

    // next: step+1; jump: target; start: start ? step+1 : target
    // reject/empty: flag ? target : step+1; last: flag ? target : stay
    typedef enum logic [2:0] {
        COND_NEXT,
        COND_JUMP,
        COND_START,
        COND_REJECT,
        COND_EMPTY,
        COND_LAST
    } t_cond;

    typedef struct packed {
        t_mul_sel mul_sel;
        logic     load_color;
        logic     wr_x0;
        logic     wr_xe;
        logic     wr_y0;
        logic     wr_ye;
        logic     wr_base;
        logic     wr_start;
        logic     emit;
        t_cond    cond;
        t_step    target;
    } t_uop;

    typedef struct packed {
        logic start;
        logic reject;
        logic empty;
        logic last;
    } t_seq_stat;

    function automatic t_uop ucode(input t_step step);
        t_uop u;
        u = '{mul_sel: MUL_NONE, load_color: 1'b0, wr_x0: 1'b0, wr_xe: 1'b0,
              wr_y0: 1'b0, wr_ye: 1'b0, wr_base: 1'b0, wr_start: 1'b0,
              emit: 1'b0, cond: COND_NEXT, target: STEP_IDLE};
        case (step)
            STEP_IDLE: begin
                u.cond = COND_START;
            end
            STEP_MUL_X0: begin
                u.mul_sel    = MUL_X0;
                u.load_color = 1'b1;
                u.cond       = COND_REJECT;
            end
            STEP_MUL_X1: begin
                u.mul_sel = MUL_X1;
                u.wr_x0   = 1'b1;
            end
            STEP_MUL_Y0: begin
                u.mul_sel = MUL_Y0;
                u.wr_xe   = 1'b1;
            end
            STEP_MUL_Y1: begin
                u.mul_sel = MUL_Y1;
                u.wr_y0   = 1'b1;
            end
            STEP_MUL_ROW: begin
                u.mul_sel = MUL_ROW;
                u.wr_ye   = 1'b1;
            end
            STEP_MUL_COL: begin
                u.mul_sel = MUL_COL;
                u.wr_base = 1'b1;
                u.cond    = COND_EMPTY;
            end
            STEP_START: begin
                u.wr_start = 1'b1;
            end
            STEP_EMIT: begin
                u.emit = 1'b1;
                u.cond = COND_LAST;
            end
            default: begin
                u.cond = COND_JUMP;
            end
        endcase
        return u;
    endfunction

    // cut a channel to its mask size and move it into place
    function automatic logic [DATA_W-1:0] place_channel(input logic [7:0] level,
                                                        input logic [FMT_W-1:0] fmt);
        logic [3:0]        size;
        logic [DATA_W-1:0] v;
        size = (fmt[3:0] > 4'd8) ? 4'd8 : fmt[3:0];
        v    = DATA_W'(level >> (4'd8 - size));
        return v << fmt[8:4];
    endfunction

endpackage

// ----- hw/rtl/gbpf_seq.sv -----
// microcode sequencer: step counter, control word table and branch logic
// depends on gbpf_pkg
module gbpf_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gbpf_pkg::t_seq_stat i_stat,
    output gbpf_pkg::t_uop      o_uop,
    output logic                o_busy
);
    import gbpf_pkg::*;

    t_step r_step;
    t_step n_step;
    t_step step_inc;
    t_uop  uop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    always_comb begin
        uop      = ucode(r_step);
        step_inc = t_step'(4'(r_step) + 4'd1);
        case (uop.cond)
            COND_NEXT:   n_step = step_inc;
            COND_JUMP:   n_step = uop.target;
            COND_START:  n_step = i_stat.start  ? step_inc   : uop.target;
            COND_REJECT: n_step = i_stat.reject ? uop.target : step_inc;
            COND_EMPTY:  n_step = i_stat.empty  ? uop.target : step_inc;
            COND_LAST:   n_step = i_stat.last   ? uop.target : r_step;
            default:     n_step = STEP_IDLE;
        endcase
    end

    assign o_uop  = uop;
    assign o_busy = (r_step != STEP_IDLE);

endmodule

// ----- hw/rtl/grid_block_pixel_fill_unit.sv -----
// top level of the grid block pixel fill unit: config registers, datapath, sequencer
// depends on gbpf_pkg and gbpf_seq
//
// Usage:
//   Command channel: an item (block column, block row, color) is taken at a clock
//   edge with start high and busy low. busy stays high until its last write.
//   Config channel: i_cfg_valid/o_cfg_ready with a register index and 64-bit data;
//   ready is always high, writes land at once and belong in idle periods.
//   Results: one framebuffer write per cycle on o_result while o_strobe is high,
//   row by row, left to right; last marks the final write of the item.
//   Sequence: after the accepting edge the sequencer steps through MUL_X0, MUL_X1,
//   MUL_Y0, MUL_Y1, MUL_ROW, MUL_COL and START, then gives one write per cycle.
//   A block past the grid limits, or with zero pixel bytes, frees the unit from
//   step MUL_X0; an empty block from step MUL_COL. The six setup steps share one
//   13x15 multiplier, which sets the fixed setup cost.
//   Reset: synchronous, active low; config returns to 640x480, pitch 2560,
//   4 bytes per pixel, 8:8:8 color at shifts 16/8/0, base 0.
//   The receiver cannot stall: every strobed write must be taken in its cycle.
module grid_block_pixel_fill_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  gbpf_pkg::t_cmd                       i_cmd,
    output logic                                 o_strobe,
    output gbpf_pkg::t_result                    o_result,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [gbpf_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [gbpf_pkg::ADDR_W-1:0]          i_cfg_data
);
    import gbpf_pkg::*;

    // configuration
    logic [ADDR_W-1:0]  r_frame_base;
    logic [W_W-1:0]     r_screen_width;
    logic [H_W-1:0]     r_screen_height;
    logic [PITCH_W-1:0] r_row_pitch;
    logic [PB_W-1:0]    r_pixel_bytes;
    logic [FMT_W-1:0]   r_red_format;
    logic [FMT_W-1:0]   r_green_format;
    logic [FMT_W-1:0]   r_blue_format;

    // datapath
    t_cmd               r_cmd;
    logic [DATA_W-1:0]  r_color,    n_color;
    logic [PROD_W-1:0]  r_prod,     n_prod;
    logic [W_W-1:0]     r_x0,       n_x0;
    logic [W_W-1:0]     r_xe,       n_xe;
    logic [H_W-1:0]     r_y0,       n_y0;
    logic [H_W-1:0]     r_ye,       n_ye;
    logic [W_W-1:0]     r_x,        n_x;
    logic [H_W-1:0]     r_y,        n_y;
    logic [CNT_W-1:0]   r_n,        n_n;
    logic [ADDR_W-1:0]  r_row_addr, n_row_addr;
    logic [ADDR_W-1:0]  r_addr,     n_addr;

    logic [W_W-1:0]     mul_a;
    logic [PITCH_W-1:0] mul_b;
    logic [PROD_W-1:0]  mul_p;
    logic [PROD_W-1:0]  x_quot;
    logic [PROD_W-1:0]  y_quot;
    logic [PB_W-1:0]    pb_sat;
    logic               row_end;
    logic               accept;

    t_uop               uop;
    t_seq_stat          stat;

    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;
    assign pb_sat      = (r_pixel_bytes > PB_MAX) ? PB_MAX : r_pixel_bytes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_base    <= RST_FRAME_BASE;
            r_screen_width  <= RST_SCREEN_WIDTH;
            r_screen_height <= RST_SCREEN_HEIGHT;
            r_row_pitch     <= RST_ROW_PITCH;
            r_pixel_bytes   <= RST_PIXEL_BYTES;
            r_red_format    <= RST_RED_FORMAT;
            r_green_format  <= RST_GREEN_FORMAT;
            r_blue_format   <= RST_BLUE_FORMAT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FRAME_BASE:    r_frame_base    <= i_cfg_data;
                CFG_SCREEN_WIDTH:  r_screen_width  <= i_cfg_data[W_W-1:0];
                CFG_SCREEN_HEIGHT: r_screen_height <= i_cfg_data[H_W-1:0];
                CFG_ROW_PITCH:     r_row_pitch     <= i_cfg_data[PITCH_W-1:0];
                CFG_PIXEL_BYTES:   r_pixel_bytes   <= i_cfg_data[PB_W-1:0];
                CFG_RED_FORMAT:    r_red_format    <= i_cfg_data[FMT_W-1:0];
                CFG_GREEN_FORMAT:  r_green_format  <= i_cfg_data[FMT_W-1:0];
                CFG_BLUE_FORMAT:   r_blue_format   <= i_cfg_data[FMT_W-1:0];
                default: ;
            endcase
        end
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (uop.mul_sel)
            MUL_X0: begin
                mul_a = r_screen_width;
                mul_b = PITCH_W'(r_cmd.block_col);
            end
            MUL_X1: begin
                mul_a = r_screen_width;
                mul_b = PITCH_W'({1'b0, r_cmd.block_col} + 11'd1);
            end
            MUL_Y0: begin
                mul_a = W_W'(r_screen_height);
                mul_b = PITCH_W'(r_cmd.block_row);
            end
            MUL_Y1: begin
                mul_a = W_W'(r_screen_height);
                mul_b = PITCH_W'({1'b0, r_cmd.block_row} + 10'd1);
            end
            MUL_ROW: begin
                mul_a = W_W'(r_y0);
                mul_b = r_row_pitch;
            end
            MUL_COL: begin
                mul_a = r_x0;
                mul_b = PITCH_W'(pb_sat);
            end
            default: ;
        endcase
    end

    assign mul_p  = mul_a * mul_b;
    assign x_quot = r_prod >> COL_SHIFT;
    assign y_quot = r_prod >> ROW_SHIFT;

    assign row_end = ({1'b0, r_x} + 14'd1) == {1'b0, r_xe};

    assign stat.start  = start;
    assign stat.reject = (r_cmd.block_col > BLOCK_COL_LIMIT)
                      || (r_cmd.block_row > BLOCK_ROW_LIMIT)
                      || (r_pixel_bytes == '0);
    assign stat.empty  = (r_x0 >= r_xe) || (r_y0 >= r_ye);
    assign stat.last   = (&r_n) || (row_end && (({1'b0, r_y} + 13'd1) == {1'b0, r_ye}));

    always_comb begin
        n_color    = r_color;
        n_prod     = r_prod;
        n_x0       = r_x0;
        n_xe       = r_xe;
        n_y0       = r_y0;
        n_ye       = r_ye;
        n_x        = r_x;
        n_y        = r_y;
        n_n        = r_n;
        n_row_addr = r_row_addr;
        n_addr     = r_addr;

        if (uop.mul_sel != MUL_NONE) begin
            n_prod = mul_p;
        end
        if (uop.load_color) begin
            n_color = place_channel(r_cmd.red,   r_red_format)
                    | place_channel(r_cmd.green, r_green_format)
                    | place_channel(r_cmd.blue,  r_blue_format);
        end
        if (uop.wr_x0) begin
            n_x0 = W_W'(x_quot);
        end
        if (uop.wr_xe) begin
            // clip the span end to the visible width
            n_xe = (x_quot > PROD_W'(r_screen_width)) ? r_screen_width : W_W'(x_quot);
        end
        if (uop.wr_y0) begin
            n_y0 = H_W'(y_quot);
        end
        if (uop.wr_ye) begin
            n_ye = (y_quot > PROD_W'(r_screen_height)) ? r_screen_height : H_W'(y_quot);
        end
        if (uop.wr_base) begin
            n_row_addr = r_frame_base + ADDR_W'(r_prod);
        end
        if (uop.wr_start) begin
            n_row_addr = r_row_addr + ADDR_W'(r_prod);
            n_addr     = r_row_addr + ADDR_W'(r_prod);
            n_x        = r_x0;
            n_y        = r_y0;
            n_n        = '0;
        end
        if (uop.emit && !stat.last) begin
            n_n = r_n + CNT_W'(1);
            if (row_end) begin
                n_x        = r_x0;
                n_y        = r_y + H_W'(1);
                n_row_addr = r_row_addr + ADDR_W'(r_row_pitch);
                n_addr     = r_row_addr + ADDR_W'(r_row_pitch);
            end else begin
                n_x    = r_x + W_W'(1);
                n_addr = r_addr + ADDR_W'(pb_sat);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_cmd;
        end
        r_color    <= n_color;
        r_prod     <= n_prod;
        r_x0       <= n_x0;
        r_xe       <= n_xe;
        r_y0       <= n_y0;
        r_ye       <= n_ye;
        r_x        <= n_x;
        r_y        <= n_y;
        r_n        <= n_n;
        r_row_addr <= n_row_addr;
        r_addr     <= n_addr;
    end

    gbpf_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_uop   (uop),
        .o_busy  (busy)
    );

    assign o_strobe               = uop.emit;
    assign o_result.write_address = r_addr;
    assign o_result.write_data    = r_color;
    assign o_result.write_bytes   = pb_sat;
    assign o_result.last          = stat.last;

endmodule

// ----- hw/rtl/gbpf_chk.sv -----
// port-level checker for the grid block pixel fill unit, bound to the top level
// depends on gbpf_pkg and grid_block_pixel_fill_unit_assert.svh
`include "grid_block_pixel_fill_unit_assert.svh"

module gbpf_chk (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_strobe,
    input gbpf_pkg::t_result o_result
);
    import gbpf_pkg::*;

    // writes only come out while an item is in flight
    `GBPF_ASSERT_IMP(a_strobe_busy, o_strobe, busy, "write strobe while not busy")

    // an accepted item raises busy
    `GBPF_ASSERT_NXT(a_accept_busy, start && !busy, busy, "busy low after accept")

    // writes of one item are back to back until last
    `GBPF_ASSERT_NXT(a_burst, o_strobe && !o_result.last, o_strobe, "gap inside write burst")

    // nothing follows the last write
    `GBPF_ASSERT_NXT(a_last_end, o_strobe && o_result.last, !o_strobe, "write after last")

    `GBPF_ASSERT_IMP(a_bytes, o_strobe, o_result.write_bytes >= 3'd1 && o_result.write_bytes <= 3'd4, "write byte count out of range")

endmodule

bind grid_block_pixel_fill_unit gbpf_chk u_gbpf_chk (.*);
